[hw/rtl/wts_pkg.sv]
`timescale 1ns / 1ps

package wts_pkg;

	// Field widths of the stream and configuration words.
	localparam int CMD_W        = 3;
	localparam int WEIGHT_W     = 24;
	localparam int DELAY_W      = 16;
	localparam int ELAPSED_W    = 32;
	localparam int MIN_W        = 6;
	localparam int SEC_W        = 6;
	localparam int TENTH_W      = 4;
	localparam int SUB_W        = 7;
	localparam int CFG_IDX_W    = 2;
	localparam int IN_TDATA_W   = 24;
	localparam int IN_TUSER_W   = 3;
	localparam int OUT_TDATA_W  = 56;
	localparam int TIME_WIDTH_DEF = 32;

	// Time base constants.
	localparam int MS_PER_TENTH    = 100;
	localparam int MS_PER_SEC      = 1000;
	localparam int MS_PER_MIN      = 60000;
	localparam int TENTHS_PER_SEC  = MS_PER_SEC / MS_PER_TENTH;
	localparam int SECS_PER_MIN    = MS_PER_MIN / MS_PER_SEC;
	localparam int MINS_PER_HOUR   = 60;

	localparam logic [SUB_W-1:0]   SUB_LAST   = SUB_W'(MS_PER_TENTH - 1);
	localparam logic [TENTH_W-1:0] TENTH_LAST = TENTH_W'(TENTHS_PER_SEC - 1);
	localparam logic [SEC_W-1:0]   SEC_LAST   = SEC_W'(SECS_PER_MIN - 1);
	localparam logic [MIN_W-1:0]   MIN_LAST   = MIN_W'(MINS_PER_HOUR - 1);

	// Command codes.
	localparam logic [CMD_W-1:0] CMD_TICK   = 3'd0;
	localparam logic [CMD_W-1:0] CMD_WEIGHT = 3'd1;
	localparam logic [CMD_W-1:0] CMD_START  = 3'd2;
	localparam logic [CMD_W-1:0] CMD_STOP   = 3'd3;
	localparam logic [CMD_W-1:0] CMD_RESET  = 3'd4;

	// Configuration register indexes.
	localparam logic [CFG_IDX_W-1:0] REG_START_THR = 2'd0;
	localparam logic [CFG_IDX_W-1:0] REG_EMPTY_THR = 2'd1;
	localparam logic [CFG_IDX_W-1:0] REG_EMPTY_DLY = 2'd2;

	// Configuration reset values.
	localparam logic signed [WEIGHT_W-1:0] START_THR_RST = 24'sd100;
	localparam logic signed [WEIGHT_W-1:0] EMPTY_THR_RST = 24'sd50;
	localparam logic [DELAY_W-1:0]         EMPTY_DLY_RST = 16'd3000;

	// One result word before packing.
	typedef struct packed {
		logic [TENTH_W-1:0]   tenths;
		logic [SEC_W-1:0]     seconds;
		logic [MIN_W-1:0]     minutes;
		logic [ELAPSED_W-1:0] elapsed_ms;
		logic                 auto_started;
		logic                 running;
	} result_t;

endpackage

[hw/rtl/weight_triggered_stopwatch.sv]
`timescale 1ns / 1ps

// Channel   Dir  Handshake                Payload
// s_*       in   s_tvalid / s_tready      s_tuser = command, s_tdata = weight
// m_*       out  m_tvalid / m_tready      m_tdata = one status word per command
// cfg_*     in   cfg_valid / cfg_ready    cfg_index, cfg_data
//
// A command is accepted into the input register; from there all state updates
// run in a single pass into the result register, which holds its status word.
// A new word is accepted every cycle unless m_tready stalls the output; the
// throughput is set by that single pass.
// arst_n clears the state, the pipeline valid flags and the configuration
// registers to their defaults. A stall on m_tready holds the result word and
// stalls the input register; s_tready drops only when both stages are full.
module weight_triggered_stopwatch
	import wts_pkg::*;
#(
	parameter int TIME_WIDTH = TIME_WIDTH_DEF
) (
	input  logic                   clk,
	input  logic                   arst_n,
	input  logic                   s_tvalid,
	output logic                   s_tready,
	input  logic [IN_TDATA_W-1:0]  s_tdata,   // [23:0] weight
	input  logic [IN_TUSER_W-1:0]  s_tuser,   // [2:0] command
	output logic                   m_tvalid,
	input  logic                   m_tready,
	// [0] running, [1] auto_started, [33:2] elapsed_ms, [39:34] minutes,
	// [45:40] seconds, [49:46] tenths, [55:50] zero
	output logic [OUT_TDATA_W-1:0] m_tdata,
	input  logic                   cfg_valid,
	output logic                   cfg_ready,
	input  logic [CFG_IDX_W-1:0]   cfg_index,
	input  logic [WEIGHT_W-1:0]    cfg_data
);

	// Configuration registers.
	logic signed [WEIGHT_W-1:0] start_thr_q;
	logic signed [WEIGHT_W-1:0] empty_thr_q;
	logic [DELAY_W-1:0]         empty_dly_q;

	// Input stage.
	logic                       valid_s1;
	logic [CMD_W-1:0]           cmd_s1;
	logic signed [WEIGHT_W-1:0] weight_s1;

	// Watch state.
	logic [TIME_WIDTH-1:0] now_q, now_d;
	logic [TIME_WIDTH-1:0] lost_q, lost_d;
	logic [ELAPSED_W-1:0]  elapsed_q, elapsed_d;
	logic [SUB_W-1:0]      sub_q, sub_d;
	logic [TENTH_W-1:0]    tenth_q, tenth_d;
	logic [SEC_W-1:0]      sec_q, sec_d;
	logic [MIN_W-1:0]      min_q, min_d;
	logic                  run_q, run_d;
	logic                  auto_q, auto_d;
	logic                  present_q, present_d;

	// Output register.
	logic    out_valid_q;
	result_t res_q;

	logic advance;
	logic fire;
	logic start_hit;
	logic [TIME_WIDTH-1:0] lost_gap;

	assign advance   = !out_valid_q || m_tready;
	assign fire      = valid_s1 && advance;
	assign s_tready  = !valid_s1 || advance;
	assign cfg_ready = 1'b1;
	assign m_tvalid  = out_valid_q;
	assign m_tdata   = {{(OUT_TDATA_W - $bits(result_t)){1'b0}}, res_q};

	// Configuration writes; an index past the list is ignored.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			start_thr_q <= START_THR_RST;
			empty_thr_q <= EMPTY_THR_RST;
			empty_dly_q <= EMPTY_DLY_RST;
		end else if (cfg_valid) begin
			unique case (cfg_index)
				REG_START_THR: start_thr_q <= cfg_data;
				REG_EMPTY_THR: empty_thr_q <= cfg_data;
				REG_EMPTY_DLY: empty_dly_q <= cfg_data[DELAY_W-1:0];
				default: ;
			endcase
		end
	end

	// Input register.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (s_tready) begin
			valid_s1 <= s_tvalid;
		end
	end

	always_ff @(posedge clk) begin
		if (s_tready && s_tvalid) begin
			cmd_s1    <= s_tuser[CMD_W-1:0];
			weight_s1 <= s_tdata[WEIGHT_W-1:0];
		end
	end

	assign start_hit = !run_q && !auto_q && (weight_s1 > start_thr_q);

	// Next state for the command in the input register.
	always_comb begin
		logic                  clear;
		logic                  p1;
		logic [TIME_WIDTH-1:0] ls1;
		clear     = 1'b0;
		p1        = start_hit ? 1'b1 : present_q;
		ls1       = start_hit ? '0 : lost_q;
		lost_gap  = now_q - ls1;
		now_d     = now_q;
		lost_d    = lost_q;
		elapsed_d = elapsed_q;
		sub_d     = sub_q;
		tenth_d   = tenth_q;
		sec_d     = sec_q;
		min_d     = min_q;
		run_d     = run_q;
		auto_d    = auto_q;
		present_d = present_q;
		unique case (cmd_s1)
			CMD_TICK: begin
				now_d = now_q + TIME_WIDTH'(1);
				if (run_q) begin
					elapsed_d = elapsed_q + ELAPSED_W'(1);
					// The digit counters restart with the count when it wraps.
					if (elapsed_q == '1) begin
						sub_d   = '0;
						tenth_d = '0;
						sec_d   = '0;
						min_d   = '0;
					end else if (sub_q != SUB_LAST) begin
						sub_d = sub_q + SUB_W'(1);
					end else begin
						sub_d = '0;
						if (tenth_q != TENTH_LAST) begin
							tenth_d = tenth_q + TENTH_W'(1);
						end else begin
							tenth_d = '0;
							if (sec_q != SEC_LAST) begin
								sec_d = sec_q + SEC_W'(1);
							end else begin
								sec_d = '0;
								min_d = (min_q == MIN_LAST) ? '0 : min_q + MIN_W'(1);
							end
						end
					end
				end
			end
			CMD_WEIGHT: begin
				run_d     = run_q || start_hit;
				auto_d    = auto_q || start_hit;
				present_d = p1;
				lost_d    = ls1;
				if (auto_q || start_hit) begin
					if (weight_s1 < empty_thr_q) begin
						if (p1) begin
							present_d = 1'b0;
							lost_d    = now_q;
						end else if (ls1 != '0 &&
								lost_gap > TIME_WIDTH'(empty_dly_q)) begin
							clear = 1'b1;
						end
					end else begin
						present_d = 1'b1;
						lost_d    = '0;
					end
				end
			end
			CMD_START: run_d = 1'b1;
			CMD_STOP:  run_d = 1'b0;
			CMD_RESET: clear = 1'b1;
			default: ;
		endcase
		// A reset keeps the millisecond clock.
		if (clear) begin
			run_d     = 1'b0;
			auto_d    = 1'b0;
			present_d = 1'b0;
			lost_d    = '0;
			elapsed_d = '0;
			sub_d     = '0;
			tenth_d   = '0;
			sec_d     = '0;
			min_d     = '0;
		end
	end

	// State update.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			now_q     <= '0;
			lost_q    <= '0;
			elapsed_q <= '0;
			sub_q     <= '0;
			tenth_q   <= '0;
			sec_q     <= '0;
			min_q     <= '0;
			run_q     <= 1'b0;
			auto_q    <= 1'b0;
			present_q <= 1'b0;
		end else if (fire) begin
			now_q     <= now_d;
			lost_q    <= lost_d;
			elapsed_q <= elapsed_d;
			sub_q     <= sub_d;
			tenth_q   <= tenth_d;
			sec_q     <= sec_d;
			min_q     <= min_d;
			run_q     <= run_d;
			auto_q    <= auto_d;
			present_q <= present_d;
		end
	end

	// Result register.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (advance) begin
			out_valid_q <= valid_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (fire) begin
			res_q.running      <= run_d;
			res_q.auto_started <= auto_d;
			res_q.elapsed_ms   <= elapsed_d;
			res_q.minutes      <= min_d;
			res_q.seconds      <= sec_d;
			res_q.tenths       <= tenth_d;
		end
	end

endmodule

[hw/rtl/wts_checker.sv]
`timescale 1ns / 1ps

module wts_checker
	import wts_pkg::*;
(
	input logic                   clk,
	input logic                   arst_n,
	input logic                   m_tvalid,
	input logic                   m_tready,
	input logic [OUT_TDATA_W-1:0] m_tdata
);

	// A stalled result word stays put.
	a_hold: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata))
		else $error("result word changed while stalled");

	// The split time fields stay inside their digit ranges.
	a_range: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid |-> (m_tdata[39:34] <= 6'd59) && (m_tdata[45:40] <= 6'd59) &&
			(m_tdata[49:46] <= 4'd9))
		else $error("time field out of range");

	// A zero count shows zero in every split field.
	a_zero: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && (m_tdata[33:2] == 32'd0) |-> (m_tdata[49:34] == 16'd0))
		else $error("split fields nonzero at zero count");

	// Padding bits are always zero.
	a_pad: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid |-> (m_tdata[55:50] == 6'd0))
		else $error("padding bits set");

endmodule

bind weight_triggered_stopwatch wts_checker u_wts_checker (
	.clk      (clk),
	.arst_n   (arst_n),
	.m_tvalid (m_tvalid),
	.m_tready (m_tready),
	.m_tdata  (m_tdata)
);

[bench/weight_triggered_stopwatch_tb.sv]
`timescale 1ns / 1ps

module weight_triggered_stopwatch_tb;
	import wts_pkg::*;

	// Command codes that the block does not use.
	localparam logic [CMD_W-1:0] CMD_SPARE_LO = 3'd5;
	localparam logic [CMD_W-1:0] CMD_SPARE_HI = 3'd7;

	localparam int IDLE_LIMIT   = 2000;
	localparam int RANDOM_PHASES = 6;
	localparam int PHASE_WORDS  = 60;
	localparam int LONG_RUN_MS  = 320;

	logic                   clk;
	logic                   arst_n;
	logic                   s_tvalid;
	logic                   s_tready;
	logic [IN_TDATA_W-1:0]  s_tdata;
	logic [IN_TUSER_W-1:0]  s_tuser;
	logic                   m_tvalid;
	logic                   m_tready;
	logic [OUT_TDATA_W-1:0] m_tdata;
	logic                   cfg_valid;
	logic                   cfg_ready;
	logic [CFG_IDX_W-1:0]   cfg_index;
	logic [WEIGHT_W-1:0]    cfg_data;

	weight_triggered_stopwatch dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.s_tvalid  (s_tvalid),
		.s_tready  (s_tready),
		.s_tdata   (s_tdata),
		.s_tuser   (s_tuser),
		.m_tvalid  (m_tvalid),
		.m_tready  (m_tready),
		.m_tdata   (m_tdata),
		.cfg_valid (cfg_valid),
		.cfg_ready (cfg_ready),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data)
	);

	// Idle rates of the two sides, in percent.
	int send_idle_pct = 38;
	int recv_stall_pct = 38;
	int mismatch_count = 0;

	// Status words that the watch must still report, oldest first.
	result_t status_due[$];

	// Own copy of the configuration registers.
	logic signed [WEIGHT_W-1:0] start_level;
	logic signed [WEIGHT_W-1:0] empty_level;
	logic [DELAY_W-1:0]         empty_hold;

	// Own copy of the watch state.
	logic [TIME_WIDTH_DEF-1:0] clock_ms;
	logic [ELAPSED_W-1:0]      elapsed;
	logic                      running;
	logic                      auto_on;
	logic                      load_seen;
	logic [TIME_WIDTH_DEF-1:0] drop_at;

	initial begin
		clk = 1'b0;
		forever #10 clk = ~clk;
	end

	// Clears the watch as a reset button or an auto reset does; the free clock keeps going.
	function automatic void clear_watch_state();
		running = 1'b0;
		auto_on = 1'b0;
		elapsed = '0;
		load_seen = 1'b0;
		drop_at = '0;
	endfunction

	// Applies one command to the watch copy and queues the status word it must produce.
	function automatic void advance_watch(logic [CMD_W-1:0] cmd, logic signed [WEIGHT_W-1:0] w);
		result_t status;
		logic [TIME_WIDTH_DEF-1:0] gap;

		case (cmd)
			CMD_TICK: begin
				clock_ms = clock_ms + 1'b1;
				if (running)
					elapsed = elapsed + 1'b1;
			end
			CMD_WEIGHT: begin
				if (!running && !auto_on && w > start_level) begin
					running = 1'b1;
					auto_on = 1'b1;
					load_seen = 1'b1;
					drop_at = '0;
				end
				if (auto_on) begin
					if (w < empty_level) begin
						// A drop time of zero means the loss was never armed.
						gap = clock_ms - drop_at;
						if (load_seen) begin
							load_seen = 1'b0;
							drop_at = clock_ms;
						end else if (drop_at != '0 && gap > TIME_WIDTH_DEF'(empty_hold)) begin
							clear_watch_state();
						end
					end else begin
						load_seen = 1'b1;
						drop_at = '0;
					end
				end
			end
			CMD_START: running = 1'b1;
			CMD_STOP:  running = 1'b0;
			CMD_RESET: clear_watch_state();
			default: ;
		endcase

		status.running      = running;
		status.auto_started = auto_on;
		status.elapsed_ms   = elapsed;
		status.minutes      = MIN_W'((elapsed / MS_PER_MIN) % MINS_PER_HOUR);
		status.seconds      = SEC_W'((elapsed / MS_PER_SEC) % SECS_PER_MIN);
		status.tenths       = TENTH_W'((elapsed / MS_PER_TENTH) % TENTHS_PER_SEC);
		status_due.push_back(status);
	endfunction

	// Sends one command word, with a random gap in front of it.
	task automatic send_cmd(input logic [CMD_W-1:0] cmd, input logic [WEIGHT_W-1:0] w);
		if ($urandom_range(99) < send_idle_pct) begin
			s_tvalid <= 1'b0;
			do @(posedge clk); while ($urandom_range(99) < send_idle_pct);
		end
		s_tvalid <= 1'b1;
		s_tuser <= cmd;
		s_tdata <= w;
		do @(posedge clk); while (!s_tready);
		advance_watch(cmd, w);
	endtask

	// A command whose weight field carries random bits that must be ignored.
	task automatic press(input logic [CMD_W-1:0] cmd);
		send_cmd(cmd, WEIGHT_W'($urandom));
	endtask

	task automatic weigh(input logic [WEIGHT_W-1:0] w);
		send_cmd(CMD_WEIGHT, w);
	endtask

	task automatic tick(input int count);
		repeat (count) press(CMD_TICK);
	endtask

	// Holds the sender until every status word has come out and the pipeline is empty.
	task automatic wait_until_quiet();
		s_tvalid <= 1'b0;
		while (status_due.size() != 0) @(posedge clk);
		repeat (4) @(posedge clk);
	endtask

	// Writes one configuration register while the watch is idle.
	task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [WEIGHT_W-1:0] value);
		wait_until_quiet();
		cfg_valid <= 1'b1;
		cfg_index <= idx;
		cfg_data <= value;
		do @(posedge clk); while (!cfg_ready);
		cfg_valid <= 1'b0;
		case (idx)
			REG_START_THR: start_level = value;
			REG_EMPTY_THR: empty_level = value;
			REG_EMPTY_DLY: empty_hold = value[DELAY_W-1:0];
			default: ;
		endcase
	endtask

	// Compares one field of a status word.
	task automatic check_field(input string name, input logic [63:0] want, input logic [63:0] got);
		if (want !== got) begin
			$display("%0t ns: %s expected %0d, got %0d", $time, name, want, got);
			mismatch_count++;
		end
	endtask

	// Checks every status word that leaves the watch and stalls the output at random.
	always @(posedge clk) begin : status_check
		result_t want;
		result_t got;

		if (arst_n && m_tvalid === 1'b1 && m_tready) begin
			got = result_t'(m_tdata[$bits(result_t)-1:0]);
			if (status_due.size() == 0) begin
				$display("%0t ns: status word with nothing expected, got %h", $time, m_tdata);
				mismatch_count++;
			end else begin
				want = status_due.pop_front();
				check_field("running", want.running, got.running);
				check_field("auto_started", want.auto_started, got.auto_started);
				check_field("elapsed_ms", want.elapsed_ms, got.elapsed_ms);
				check_field("minutes", want.minutes, got.minutes);
				check_field("seconds", want.seconds, got.seconds);
				check_field("tenths", want.tenths, got.tenths);
			end
		end
		m_tready <= ($urandom_range(99) >= recv_stall_pct);
	end

	// Ends the run when no word moves on any channel for too long.
	initial begin : watchdog
		int quiet;

		quiet = 0;
		while (quiet < IDLE_LIMIT) begin
			@(posedge clk);
			if (!arst_n || (s_tvalid && s_tready) || (m_tvalid && m_tready)
					|| (cfg_valid && cfg_ready))
				quiet = 0;
			else
				quiet++;
		end
		$display("CHECK FAILED");
		$finish;
	end

	// Drops the load while the free clock is still zero, then checks a short delay.
	task automatic test_zero_timestamp();
		write_reg(REG_EMPTY_DLY, 24'd12);
		weigh(24'sd100);
		weigh(24'sd101);
		weigh(24'sd49);
		tick(4);
		weigh(-24'sd8388608);
		weigh(24'sd50);
		tick(1);
		weigh(24'sd49);
		tick(12);
		weigh(24'sd49);
		tick(1);
		weigh(24'sd49);
		press(CMD_SPARE_LO);
		press(CMD_SPARE_LO + 3'd1);
		press(CMD_SPARE_HI);
	endtask

	// Start, stop and reset buttons, repeated presses and extreme weights.
	task automatic test_buttons();
		press(CMD_RESET);
		press(CMD_STOP);
		tick(1);
		press(CMD_START);
		press(CMD_START);
		tick(3);
		press(CMD_STOP);
		tick(2);
		press(CMD_STOP);
		weigh(24'sd8388607);
		press(CMD_STOP);
		weigh(24'sd8388607);
		weigh(-24'sd8388608);
		press(CMD_START);
		tick(2);
		press(CMD_RESET);
	endtask

	// Thresholds at their limits, first unreachable, then inverted.
	task automatic test_threshold_limits();
		write_reg(REG_START_THR, 24'h7FFFFF);
		write_reg(REG_EMPTY_THR, 24'h800000);
		write_reg(REG_EMPTY_DLY, 24'h000000);
		weigh(24'sd8388607);
		weigh(-24'sd8388608);
		tick(1);
		write_reg(REG_START_THR, 24'h800000);
		write_reg(REG_EMPTY_THR, 24'h7FFFFF);
		weigh(-24'sd8388608);
		weigh(24'sd0);
		weigh(24'sd0);
		tick(1);
		weigh(-24'sd1);
		press(CMD_RESET);
	endtask

	// A long run without any idling, with the longest delay armed.
	task automatic test_long_run();
		write_reg(REG_START_THR, 24'd100);
		write_reg(REG_EMPTY_THR, 24'd50);
		write_reg(REG_EMPTY_DLY, 24'hFFFFFF);
		send_idle_pct = 0;
		recv_stall_pct = 0;
		weigh(24'sd200);
		weigh(24'sd0);
		tick(LONG_RUN_MS);
		weigh(24'sd0);
		press(CMD_STOP);
		press(CMD_RESET);
		send_idle_pct = 38;
		recv_stall_pct = 38;
	endtask

	function automatic logic [WEIGHT_W-1:0] pick_level();
		if ($urandom_range(7) == 0)
			return WEIGHT_W'($urandom);
		return WEIGHT_W'(int'($urandom_range(400)) - 200);
	endfunction

	// A weight close to one of the two thresholds, now and then any weight at all.
	function automatic logic [WEIGHT_W-1:0] pick_weight();
		logic signed [WEIGHT_W-1:0] level;

		if ($urandom_range(99) < 15)
			return WEIGHT_W'($urandom);
		level = $urandom_range(1) ? start_level : empty_level;
		return WEIGHT_W'(int'(level) + int'($urandom_range(8)) - 4);
	endfunction

	// Random commands in several phases, each with its own settings.
	task automatic test_random_traffic();
		logic signed [WEIGHT_W-1:0] level;
		logic [WEIGHT_W-1:0] hold;
		int roll;

		for (int phase = 0; phase < RANDOM_PHASES; phase++) begin
			level = pick_level();
			write_reg(REG_START_THR, level);
			if ($urandom_range(9) < 7)
				write_reg(REG_EMPTY_THR, WEIGHT_W'(int'(level) - int'($urandom_range(80))));
			else
				write_reg(REG_EMPTY_THR, pick_level());
			hold = WEIGHT_W'($urandom);
			if (phase == 0)
				hold[DELAY_W-1:0] = '0;
			else if (phase == RANDOM_PHASES - 1)
				hold[DELAY_W-1:0] = '1;
			else if ($urandom_range(3) != 0)
				hold[DELAY_W-1:0] = DELAY_W'($urandom_range(40));
			write_reg(REG_EMPTY_DLY, hold);

			// One phase runs with both sides at full speed.
			send_idle_pct = (phase == 3) ? 0 : 38;
			recv_stall_pct = (phase == 3) ? 0 : 38;

			for (int n = 0; n < PHASE_WORDS; n++) begin
				if (n == PHASE_WORDS / 2)
					wait_until_quiet();
				roll = $urandom_range(99);
				if (roll < 45)
					press(CMD_TICK);
				else if (roll < 85)
					weigh(pick_weight());
				else if (roll < 89)
					press(CMD_START);
				else if (roll < 94)
					press(CMD_STOP);
				else if (roll < 97)
					press(CMD_RESET);
				else
					press(CMD_SPARE_HI - 3'($urandom_range(2)));
			end
		end
		send_idle_pct = 38;
		recv_stall_pct = 38;
	endtask

	initial begin
		arst_n <= 1'b0;
		s_tvalid <= 1'b0;
		s_tdata <= '0;
		s_tuser <= CMD_TICK;
		cfg_valid <= 1'b0;
		cfg_index <= REG_START_THR;
		cfg_data <= '0;

		start_level = START_THR_RST;
		empty_level = EMPTY_THR_RST;
		empty_hold = EMPTY_DLY_RST;
		clock_ms = '0;
		clear_watch_state();

		repeat (6) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		test_zero_timestamp();
		test_buttons();
		test_threshold_limits();
		test_long_run();
		test_random_traffic();

		// Let the last status words drain before the verdict.
		s_tvalid <= 1'b0;
		while (status_due.size() != 0) @(posedge clk);
		repeat (10) @(posedge clk);
		if (mismatch_count == 0)
			$display("CHECK OK");
		else
			$display("CHECK FAILED");
		$finish;
	end

endmodule
